### design/rgl_pkg.sv
// Shared types and constants for the rectangle gradient line colour block.
// No dependencies; imported by every module of the block.
package rgl_pkg;

   // Red, green and blue lanes run side by side through the pipeline
   localparam int NUM_LANES = 3;

   // Per-item line flags carried alongside the colour data
   typedef struct packed {
      logic valid_res;
      logic columns;
      logic last_line;
      logic span_zero;
   } line_flags_type;

   localparam int FLAGS_W = $bits(line_flags_type);

endpackage

### design/rect_gradient_line_colour.sv
// Gradient line colour: one transfer per cycle while rsp_stall is low, through two geometry
// stages, one multiply stage, one divider stage per quotient bit and a registered output
// stage; under rsp_stall each full stage holds while empty stages upstream still fill.
// Synchronous active-high reset empties every stage; datapath registers are not reset.
// Depends on rgl_pkg, rgl_geom, rgl_mul and rgl_div_step.
module rect_gradient_line_colour import rgl_pkg::*; #(
   parameter int COORD_BITS   = 16,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_BITS-1:0]   req_left,
   input  logic signed [COORD_BITS-1:0]   req_top_edge,
   input  logic signed [COORD_BITS-1:0]   req_right,
   input  logic signed [COORD_BITS-1:0]   req_bottom_edge,
   input  logic [CHANNEL_BITS-1:0]        req_start_red,
   input  logic [CHANNEL_BITS-1:0]        req_start_green,
   input  logic [CHANNEL_BITS-1:0]        req_start_blue,
   input  logic [CHANNEL_BITS-1:0]        req_end_red,
   input  logic [CHANNEL_BITS-1:0]        req_end_green,
   input  logic [CHANNEL_BITS-1:0]        req_end_blue,
   input  logic [COORD_BITS-1:0]          req_step,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_valid_res,
   output logic                           rsp_columns,
   output logic signed [COORD_BITS-1:0]   rsp_line_position,
   output logic                           rsp_last_line,
   output logic [CHANNEL_BITS-1:0]        rsp_out_red,
   output logic [CHANNEL_BITS-1:0]        rsp_out_green,
   output logic [CHANNEL_BITS-1:0]        rsp_out_blue
);

   localparam int C      = COORD_BITS;
   localparam int K      = CHANNEL_BITS;
   localparam int SIDE_W = C + NUM_LANES + NUM_LANES * K + FLAGS_W;
   localparam int DEPTH  = K + 4;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // geometry to multiply
   logic                            geom_ready, geom_valid, mul_ready;
   line_flags_type                  geom_flags;
   logic [C-1:0]                    geom_span, geom_step, geom_position;
   logic [NUM_LANES-1:0][K-1:0]     geom_mag, geom_start;
   logic [NUM_LANES-1:0]            geom_neg;
   logic [NUM_LANES-1:0][K-1:0]     req_start_col, req_end_col;

   // divider chain, index 0 is the multiply stage output
   logic                            chain_valid [K+1];
   logic                            chain_ready [K+1];
   logic [NUM_LANES-1:0][C-1:0]     rem_c  [K+1];
   logic [NUM_LANES-1:0][K-1:0]     low_c  [K+1];
   logic [C-1:0]                    span_c [K+1];
   logic [SIDE_W-1:0]               side_c [K+1];

   // output stage
   logic                            out_v_ff;
   logic                            out_ready;
   line_flags_type                  fin_flags;
   logic [NUM_LANES-1:0][K-1:0]     fin_start;
   logic [NUM_LANES-1:0]            fin_neg;
   logic [C-1:0]                    fin_position;
   logic [NUM_LANES-1:0][K-1:0]     colour_in, colour_ff;
   line_flags_type                  flags_ff;
   logic [C-1:0]                    position_ff;

   logic [CNT_W-1:0]                flight_ff, flight_in;

   assign req_start_col = {req_start_blue, req_start_green, req_start_red};
   assign req_end_col   = {req_end_blue, req_end_green, req_end_red};
   assign req_stall     = !geom_ready;

   rgl_geom #(
      .COORD_BITS   (C),
      .CHANNEL_BITS (K)
   ) u_geom (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (geom_ready),
      .left         (req_left),
      .top_edge     (req_top_edge),
      .right        (req_right),
      .bottom_edge  (req_bottom_edge),
      .start_col    (req_start_col),
      .end_col      (req_end_col),
      .step         (req_step),
      .out_valid    (geom_valid),
      .out_ready    (mul_ready),
      .out_flags    (geom_flags),
      .out_span     (geom_span),
      .out_step     (geom_step),
      .out_position (geom_position),
      .out_mag      (geom_mag),
      .out_neg      (geom_neg),
      .out_start    (geom_start)
   );

   rgl_mul #(
      .COORD_BITS   (C),
      .CHANNEL_BITS (K),
      .SIDE_W       (SIDE_W)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (geom_valid),
      .in_ready     (mul_ready),
      .in_flags     (geom_flags),
      .in_span      (geom_span),
      .in_step      (geom_step),
      .in_position  (geom_position),
      .in_mag       (geom_mag),
      .in_neg       (geom_neg),
      .in_start     (geom_start),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_rem      (rem_c[0]),
      .out_low      (low_c[0]),
      .out_span     (span_c[0]),
      .out_side     (side_c[0])
   );

   // one stage per quotient bit, most significant first
   for (genvar j = 0; j < K; j++) begin : g_div
      rgl_div_step #(
         .COORD_BITS   (C),
         .CHANNEL_BITS (K),
         .SIDE_W       (SIDE_W)
      ) u_div_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[j]),
         .in_ready  (chain_ready[j]),
         .in_rem    (rem_c[j]),
         .in_low    (low_c[j]),
         .in_span   (span_c[j]),
         .in_side   (side_c[j]),
         .out_valid (chain_valid[j+1]),
         .out_ready (chain_ready[j+1]),
         .out_rem   (rem_c[j+1]),
         .out_low   (low_c[j+1]),
         .out_span  (span_c[j+1]),
         .out_side  (side_c[j+1])
      );
   end

   // final stage: apply the quotient to the start colour, zero failed results
   assign out_ready      = !out_v_ff || !rsp_stall;
   assign chain_ready[K] = out_ready;

   always_comb begin
      fin_flags    = line_flags_type'(side_c[K][FLAGS_W-1:0]);
      fin_start    = side_c[K][FLAGS_W +: NUM_LANES*K];
      fin_neg      = side_c[K][FLAGS_W + NUM_LANES*K +: NUM_LANES];
      fin_position = side_c[K][FLAGS_W + NUM_LANES*K + NUM_LANES +: C];
      for (int l = 0; l < NUM_LANES; l++) begin
         if (!fin_flags.valid_res) begin
            colour_in[l] = '0;
         end else if (fin_flags.span_zero) begin
            colour_in[l] = fin_start[l];
         end else if (fin_neg[l]) begin
            colour_in[l] = fin_start[l] - low_c[K][l];
         end else begin
            colour_in[l] = fin_start[l] + low_c[K][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= chain_valid[K];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[K]) begin
         colour_ff <= colour_in;
         if (fin_flags.valid_res) begin
            flags_ff    <= fin_flags;
            position_ff <= fin_position;
         end else begin
            flags_ff    <= '0;
            position_ff <= '0;
         end
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_valid_res     = flags_ff.valid_res;
   assign rsp_columns       = flags_ff.columns;
   assign rsp_last_line     = flags_ff.last_line;
   assign rsp_line_position = position_ff;
   assign rsp_out_red       = colour_ff[0];
   assign rsp_out_green     = colour_ff[1];
   assign rsp_out_blue      = colour_ff[2];

   // items in flight, for checking only
   always_comb begin
      flight_in = flight_ff;
      if (req_valid && !req_stall) flight_in = flight_in + CNT_W'(1);
      if (rsp_valid && !rsp_stall) flight_in = flight_in - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // never more items held than the pipeline has stages
   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= CNT_W'(DEPTH))
      else $error("more items in flight than pipeline stages");

   // the input side only stalls when the output is full and stalled
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   // a failed result carries no position or colour
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_line_position == '0 && rsp_out_red == '0 && rsp_out_green == '0
          && rsp_out_blue == '0 && !rsp_columns && !rsp_last_line))
      else $error("failed result with non-zero fields");

   // for a drawn line the final remainders stay below a non-zero span
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[K] && fin_flags.valid_res && span_c[K] != '0) |->
         (rem_c[K][0] < span_c[K] && rem_c[K][1] < span_c[K] && rem_c[K][2] < span_c[K]))
      else $error("divider remainder not below span");

endmodule

### design/rgl_geom.sv
// Front end of the gradient pipeline: two register stages of rectangle geometry.
// Depends on rgl_pkg for the line flag struct and lane count.
module rgl_geom import rgl_pkg::*; #(
   parameter int COORD_BITS   = 16,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [COORD_BITS-1:0]                    left,
   input  logic [COORD_BITS-1:0]                    top_edge,
   input  logic [COORD_BITS-1:0]                    right,
   input  logic [COORD_BITS-1:0]                    bottom_edge,
   input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   start_col,
   input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   end_col,
   input  logic [COORD_BITS-1:0]                    step,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output line_flags_type                           out_flags,
   output logic [COORD_BITS-1:0]                    out_span,
   output logic [COORD_BITS-1:0]                    out_step,
   output logic [COORD_BITS-1:0]                    out_position,
   output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   out_mag,
   output logic [NUM_LANES-1:0]                     out_neg,
   output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   out_start
);

   localparam int C = COORD_BITS;
   localparam int K = CHANNEL_BITS;

   // stage 1 registers
   logic                            v1_ff;
   logic [C:0]                      dx_ff, dy_ff;
   logic [C:0]                      dx_in, dy_in;
   logic [C-1:0]                    x1_ff, y1_ff, step1_ff;
   logic [NUM_LANES-1:0][K-1:0]     mag1_ff, mag1_in, start1_ff;
   logic [NUM_LANES-1:0]            neg1_ff, neg1_in;

   // stage 2 registers
   logic                            v2_ff;
   line_flags_type                  flags_ff, flags_in;
   logic [C-1:0]                    span_ff, span_in;
   logic [C-1:0]                    step2_ff;
   logic [C-1:0]                    position_ff, position_in;
   logic [NUM_LANES-1:0][K-1:0]     mag2_ff, start2_ff;
   logic [NUM_LANES-1:0]            neg2_ff;

   logic                            ready1, ready2;
   logic                            inverted;
   logic [C:0]                      width_w, half_h;
   logic                            cols;

   // stall chain
   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: signed extents and colour differences
   always_comb begin
      dx_in = {right[C-1], right} - {left[C-1], left};
      dy_in = {bottom_edge[C-1], bottom_edge} - {top_edge[C-1], top_edge};
      for (int l = 0; l < NUM_LANES; l++) begin
         neg1_in[l] = end_col[l] < start_col[l];
         mag1_in[l] = neg1_in[l] ? start_col[l] - end_col[l] : end_col[l] - start_col[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         x1_ff     <= left;
         y1_ff     <= top_edge;
         step1_ff  <= step;
         mag1_ff   <= mag1_in;
         neg1_ff   <= neg1_in;
         start1_ff <= start_col;
      end
   end

   // stage 2: line direction, span, position and flags
   always_comb begin
      inverted = dx_ff[C] || dy_ff[C];
      width_w  = {1'b0, dx_ff[C-1:0]} + (C+1)'(1);
      half_h   = ({1'b0, dy_ff[C-1:0]} + (C+1)'(1)) >> 1;
      cols     = !(width_w > half_h);
      span_in     = cols ? dx_ff[C-1:0] : dy_ff[C-1:0];
      position_in = (cols ? x1_ff : y1_ff) + step1_ff;
      flags_in.valid_res = !inverted && (step1_ff <= span_in);
      flags_in.columns   = cols;
      flags_in.last_line = step1_ff == span_in;
      flags_in.span_zero = span_in == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         flags_ff    <= flags_in;
         span_ff     <= span_in;
         step2_ff    <= step1_ff;
         position_ff <= position_in;
         mag2_ff     <= mag1_ff;
         neg2_ff     <= neg1_ff;
         start2_ff   <= start1_ff;
      end
   end

   assign out_valid    = v2_ff;
   assign out_flags    = flags_ff;
   assign out_span     = span_ff;
   assign out_step     = step2_ff;
   assign out_position = position_ff;
   assign out_mag      = mag2_ff;
   assign out_neg      = neg2_ff;
   assign out_start    = start2_ff;

endmodule

### design/rgl_mul.sv
// Product stage: colour difference magnitude times step, per lane.
// Depends on rgl_pkg; feeds the first divider stage with remainder and low bits.
module rgl_mul import rgl_pkg::*; #(
   parameter int COORD_BITS   = 16,
   parameter int CHANNEL_BITS = 8,
   parameter int SIDE_W       = 16 + 3 + 24 + 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  line_flags_type                           in_flags,
   input  logic [COORD_BITS-1:0]                    in_span,
   input  logic [COORD_BITS-1:0]                    in_step,
   input  logic [COORD_BITS-1:0]                    in_position,
   input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   in_mag,
   input  logic [NUM_LANES-1:0]                     in_neg,
   input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   in_start,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [NUM_LANES-1:0][COORD_BITS-1:0]     out_rem,
   output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   out_low,
   output logic [COORD_BITS-1:0]                    out_span,
   output logic [SIDE_W-1:0]                        out_side
);

   localparam int C = COORD_BITS;
   localparam int K = CHANNEL_BITS;
   localparam int P = C + K;

   logic                            v_ff;
   logic [NUM_LANES-1:0][P-1:0]     prod_in;
   logic [NUM_LANES-1:0][C-1:0]     rem_ff;
   logic [NUM_LANES-1:0][K-1:0]     low_ff;
   logic [C-1:0]                    span_ff;
   logic [SIDE_W-1:0]               side_ff, side_in;
   logic                            ready;

   assign ready    = !v_ff || out_ready;
   assign in_ready = ready;

   // products; the upper bits start the divider remainder, below the span
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         prod_in[l] = P'(in_mag[l]) * P'(in_step);
      end
      side_in = {in_position, in_neg, in_start, in_flags};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            rem_ff[l] <= prod_in[l][P-1:K];
            low_ff[l] <= prod_in[l][K-1:0];
         end
         span_ff <= in_span;
         side_ff <= side_in;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_span  = span_ff;
   assign out_side  = side_ff;

endmodule

### design/rgl_div_step.sv
// One restoring division stage: one quotient bit per lane, registered.
// Depends on rgl_pkg for the lane count; chained by the top level.
module rgl_div_step import rgl_pkg::*; #(
   parameter int COORD_BITS   = 16,
   parameter int CHANNEL_BITS = 8,
   parameter int SIDE_W       = 16 + 3 + 24 + 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [NUM_LANES-1:0][COORD_BITS-1:0]     in_rem,
   input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   in_low,
   input  logic [COORD_BITS-1:0]                    in_span,
   input  logic [SIDE_W-1:0]                        in_side,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [NUM_LANES-1:0][COORD_BITS-1:0]     out_rem,
   output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0]   out_low,
   output logic [COORD_BITS-1:0]                    out_span,
   output logic [SIDE_W-1:0]                        out_side
);

   localparam int C = COORD_BITS;
   localparam int K = CHANNEL_BITS;

   logic                            v_ff;
   logic [NUM_LANES-1:0][C-1:0]     rem_ff, rem_in;
   logic [NUM_LANES-1:0][K-1:0]     low_ff, low_in;
   logic [C-1:0]                    span_ff;
   logic [SIDE_W-1:0]               side_ff;
   logic [NUM_LANES-1:0][C:0]       trial;
   logic [NUM_LANES-1:0]            fits;
   logic                            ready;

   assign ready    = !v_ff || out_ready;
   assign in_ready = ready;

   // shift in the next dividend bit, subtract span if it fits;
   // quotient bits fill the low word from the bottom
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         trial[l]  = {in_rem[l], in_low[l][K-1]};
         fits[l]   = trial[l] >= {1'b0, in_span};
         rem_in[l] = fits[l] ? C'(trial[l] - {1'b0, in_span}) : trial[l][C-1:0];
         low_in[l] = {in_low[l][K-2:0], fits[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         span_ff <= in_span;
         side_ff <= in_side;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_span  = span_ff;
   assign out_side  = side_ff;

endmodule
